[rtl/hidfd_pkg.sv]
// Package: types and constants shared by the wireless HID frame decoder.
`timescale 1ns / 1ps
package hidfd_pkg;

    localparam int unsigned CountW   = 5;
    localparam int unsigned BodyW    = 48;
    localparam int unsigned BodyLanes = 6;

    localparam logic [CountW-1:0] CountMax  = 5'd23;
    localparam logic [CountW-1:0] LenMin    = 5'd5;
    localparam logic [CountW-1:0] LenMax    = 5'd22;
    localparam logic [CountW-1:0] LenKeep   = 5'd5;
    localparam logic [CountW-1:0] LenReport = 5'd10;
    localparam logic [CountW-1:0] LenCrypt  = 5'd22;
    localparam logic [CountW-1:0] IdxDevice = 5'd0;
    localparam logic [CountW-1:0] IdxType   = 5'd1;
    localparam logic [CountW-1:0] IdxSecond = 5'd2;
    localparam logic [CountW-1:0] IdxBody   = 5'd3;

    localparam logic [7:0] TypeKeepalive = 8'h40;
    localparam logic [7:0] TypeKey       = 8'hC1;
    localparam logic [7:0] TypeMouse     = 8'hC2;
    localparam logic [7:0] TypeMedia     = 8'hC3;
    localparam logic [7:0] TypeEncrypted = 8'hD3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_TYPE     = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_CHECKSUM = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        KIND_KEEPALIVE = 3'd0,
        KIND_KEY       = 3'd1,
        KIND_MOUSE     = 3'd2,
        KIND_MEDIA     = 3'd3,
        KIND_ENCRYPTED = 3'd4
    } t_kind;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [7:0]        sum;
        logic [7:0]        device;
        logic [7:0]        type_byte;
        logic [7:0]        second;
        logic [BodyW-1:0]  body;
    } t_frame;

    typedef struct packed {
        t_status           status;
        t_kind             kind;
        logic [7:0]        device_index;
        logic [7:0]        modifier_bits;
        logic [7:0]        button_bits;
        logic [7:0]        media_code;
        logic [7:0]        timeout_value;
        logic [BodyW-1:0]  key_codes;
        logic [11:0]       delta_x;
        logic [11:0]       delta_y;
    } t_result;

endpackage

[rtl/wireless_hid_frame_decoder.sv]
// Top level of the wireless HID frame decoder.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | i_valid / o_ready   | i_byte_value, i_last_byte
//   out     | o_valid / i_ready   | o_status, o_kind, o_device_index, ... o_delta_y
//
// One byte beat per cycle while o_ready is high. Frame state updates on the accepting edge; the
// result of a last-byte beat appears in the result register on the next cycle.
// o_ready is low only while a result waits and i_ready is low.
// Synchronous active-low reset empties the frame state and clears the result valid flag.
`timescale 1ns / 1ps
module wireless_hid_frame_decoder
    import hidfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte_value,
    input  logic                i_last_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [2:0]          o_kind,
    output logic [7:0]          o_device_index,
    output logic [7:0]          o_modifier_bits,
    output logic [7:0]          o_button_bits,
    output logic [7:0]          o_media_code,
    output logic [7:0]          o_timeout_value,
    output logic [47:0]         o_key_codes,
    output logic signed [11:0]  o_delta_x,
    output logic signed [11:0]  o_delta_y
);

    logic    accept;
    t_frame  frame;
    t_result result;
    t_result r_result;
    logic    r_valid;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    hidfd_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_frame      (frame)
    );

    hidfd_decode u_decode (
        .i_frame  (frame),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept && i_last_byte) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_result <= result;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_result.status;
    assign o_kind          = r_result.kind;
    assign o_device_index  = r_result.device_index;
    assign o_modifier_bits = r_result.modifier_bits;
    assign o_button_bits   = r_result.button_bits;
    assign o_media_code    = r_result.media_code;
    assign o_timeout_value = r_result.timeout_value;
    assign o_key_codes     = r_result.key_codes;
    assign o_delta_x       = r_result.delta_x;
    assign o_delta_y       = r_result.delta_y;

endmodule

[rtl/hidfd_accum.sv]
// Frame accumulator: byte count, running sum and captured header/body bytes.
`timescale 1ns / 1ps
module hidfd_accum
    import hidfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_byte_value,
    input  logic         i_last_byte,
    output t_frame       o_frame
);

    t_frame r_frame;
    t_frame n_frame;

    always_comb begin
        n_frame = r_frame;
        if (r_frame.count == IdxDevice) begin
            n_frame.device = i_byte_value;
        end
        if (r_frame.count == IdxType) begin
            n_frame.type_byte = i_byte_value;
        end
        if (r_frame.count == IdxSecond) begin
            n_frame.second = i_byte_value;
        end
        for (int k = 0; k < BodyLanes; k++) begin
            if (r_frame.count == IdxBody + CountW'(k)) begin
                n_frame.body[k*8 +: 8] = i_byte_value;
            end
        end
        n_frame.sum = r_frame.sum + i_byte_value;
        if (r_frame.count < CountMax) begin
            n_frame.count = r_frame.count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_accept) begin
            // frame end returns to the empty state
            r_frame <= i_last_byte ? '0 : n_frame;
        end
    end

    assign o_frame = n_frame;

endmodule

[rtl/hidfd_decode.sv]
// Frame checker and field decoder for a completed frame.
`timescale 1ns / 1ps
module hidfd_decode
    import hidfd_pkg::*;
(
    input  t_frame  i_frame,
    output t_result o_result
);

    logic [CountW-1:0] want;
    t_kind             kind;
    logic              known;

    always_comb begin
        known = 1'b1;
        want  = LenKeep;
        kind  = KIND_KEEPALIVE;
        unique case (i_frame.type_byte)
            TypeKeepalive: begin
                want = LenKeep;
                kind = KIND_KEEPALIVE;
            end
            TypeKey: begin
                want = LenReport;
                kind = KIND_KEY;
            end
            TypeMouse: begin
                want = LenReport;
                kind = KIND_MOUSE;
            end
            TypeMedia: begin
                want = LenReport;
                kind = KIND_MEDIA;
            end
            TypeEncrypted: begin
                want = LenCrypt;
                kind = KIND_ENCRYPTED;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        if (i_frame.count < LenMin || i_frame.count > LenMax) begin
            o_result.status = ST_LENGTH;
        end else if (!known) begin
            o_result.status = ST_TYPE;
        end else if (i_frame.count != want) begin
            o_result.status = ST_MISMATCH;
        end else if (i_frame.sum != 8'd0) begin
            o_result.status = ST_CHECKSUM;
        end else begin
            o_result.status       = ST_OK;
            o_result.kind         = kind;
            o_result.device_index = i_frame.device;
            unique case (kind)
                KIND_KEEPALIVE: begin
                    o_result.timeout_value = i_frame.body[7:0];
                end
                KIND_KEY: begin
                    o_result.modifier_bits = i_frame.second;
                    o_result.key_codes     = i_frame.body;
                end
                KIND_MOUSE: begin
                    o_result.button_bits = i_frame.second;
                    o_result.delta_x     = i_frame.body[19:8];
                    o_result.delta_y     = i_frame.body[31:20];
                end
                KIND_MEDIA: begin
                    o_result.media_code = i_frame.second;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/hidfd_checker.sv]
// Port-level checker for the wireless HID frame decoder, with its bind.
`timescale 1ns / 1ps
module hidfd_checker
    import hidfd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [2:0]          o_status,
    input logic [2:0]          o_kind,
    input logic [7:0]          o_device_index,
    input logic [7:0]          o_button_bits,
    input logic [47:0]         o_key_codes,
    input logic signed [11:0]  o_delta_x,
    input logic signed [11:0]  o_delta_y
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_key_codes))
        else $error("stalled result beat changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |->
            o_kind == 3'd0 && o_device_index == 8'd0 && o_key_codes == 48'd0)
        else $error("rejected frame carries data");

    a_mouse_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_MOUSE |->
            o_button_bits == 8'd0 && o_delta_x == 12'sd0 && o_delta_y == 12'sd0)
        else $error("mouse fields set on non-mouse result");

endmodule

bind wireless_hid_frame_decoder hidfd_checker u_hidfd_checker (.*);
